// ----- rtl/core/crc8fc_pkg.sv -----
// shared types, constants and the crc-8 update function for the frame checker
package crc8fc_pkg;

	// frame layout
	localparam int HEADER_BYTES_DEF = 7;
	localparam int QUEUE_DEPTH      = 2;

	// crc-8 generator, msb first
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	// result status codes
	localparam logic [1:0] STATUS_UNFINISHED = 2'd0;
	localparam logic [1:0] STATUS_VALID      = 2'd1;
	localparam logic [1:0] STATUS_INVALID    = 2'd2;

	// register indexes on the configuration port
	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_CRC_SEED     = 1'b1;

	// what the back end does with one byte
	typedef enum logic [1:0] {
		KIND_FIRST,  // first header byte, crc starts from seed
		KIND_BODY,   // header or payload byte, crc continues
		KIND_BAD,    // start byte mismatch, frame rejected
		KIND_CHECK   // crc byte, compare and give verdict
	} kind_t;

	// classified word from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] plen;
	} job_t;

	// result word
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] plen;
	} res_t;

	// one byte through the crc, eight shift steps
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 8'd0) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/crc8_frame_checker.sv -----
// crc-8 framed packet checker, top level with configuration registers
// a byte's status is registered in the tracker-to-engine queue and then in the result queue before it can be popped
// throughput: one byte per cycle while neither queue is full, set by the unrolled combinational crc-8 update
// a 2-word queue sits between the frame tracker and the crc engine, another at the result side
// reset: start marker and seed clear to 0, frame tracking restarts, both queues empty
module crc8_frame_checker #(
	parameter int HEADER_BYTES = crc8fc_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        push,
	input  logic [7:0]  data_byte,
	output logic        full,
	// status output
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  status,
	output logic [7:0]  payload_length,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import crc8fc_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] crc_seed_q;
	logic       cfg_write;
	logic       reg_index;

	logic       in_take;
	job_t       front_job;
	logic       mid_full;
	logic       mid_empty;
	job_t       mid_job;
	logic       back_take;
	res_t       back_res;
	logic       out_full;
	res_t       out_res;

	// configuration registers
	assign pready    = 1'b1;
	assign reg_index = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
			crc_seed_q     <= '0;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_START_MARKER: start_marker_q <= pwdata[7:0];
				REG_CRC_SEED:     crc_seed_q     <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (reg_index)
			REG_START_MARKER: prdata = {24'd0, start_marker_q};
			REG_CRC_SEED:     prdata = {24'd0, crc_seed_q};
		endcase
	end

	// front: frame tracking
	assign full    = mid_full;
	assign in_take = push && !mid_full;

	crc8fc_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_take),
		.data_byte   (data_byte),
		.start_marker(start_marker_q),
		.job         (front_job)
	);

	// queue between tracker and crc engine
	crc8fc_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (in_take),
		.wdata (front_job),
		.full  (mid_full),
		.pop   (back_take),
		.rdata (mid_job),
		.empty (mid_empty)
	);

	// back: crc and verdict
	assign back_take = !mid_empty && !out_full;

	crc8fc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (back_take),
		.job     (mid_job),
		.crc_seed(crc_seed_q),
		.res     (back_res)
	);

	// result queue
	crc8fc_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (back_take),
		.wdata (back_res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign status         = out_res.status;
	assign payload_length = out_res.plen;

endmodule

// ----- rtl/core/crc8fc_fifo.sv -----
// small register queue used between the checker stages and at the result side
module crc8fc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = crc8fc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// handshake
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/crc8fc_front.sv -----
// frame tracker: counts bytes and tags each byte with what the back end must do
module crc8fc_front #(
	parameter int HEADER_BYTES = crc8fc_pkg::HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        data_byte,
	input  logic [7:0]        start_marker,
	output crc8fc_pkg::job_t  job
);
	import crc8fc_pkg::*;

	localparam int CNT_W = $clog2(HEADER_BYTES + 256);

	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       first_byte_q;
	logic [7:0]       plen_q;
	logic [CNT_W-1:0] crc_index;
	logic             in_header;
	logic             bad_start;
	logic             at_crc;
	logic             restart;

	// byte classification
	assign crc_index = CNT_W'(HEADER_BYTES) + CNT_W'(plen_q);
	assign in_header = (byte_count_q < CNT_W'(HEADER_BYTES));
	assign bad_start = (byte_count_q == CNT_W'(HEADER_BYTES)) && (first_byte_q != start_marker);
	assign at_crc    = (byte_count_q >= crc_index);
	assign restart   = !in_header && (bad_start || at_crc);

	always_comb begin
		job.data = data_byte;
		job.plen = plen_q;
		if (in_header) begin
			job.kind = (byte_count_q == '0) ? KIND_FIRST : KIND_BODY;
		end else if (bad_start) begin
			job.kind = KIND_BAD;
		end else if (at_crc) begin
			job.kind = KIND_CHECK;
		end else begin
			job.kind = KIND_BODY;
		end
	end

	// frame position and captured header fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			first_byte_q <= '0;
			plen_q       <= '0;
		end else if (take) begin
			byte_count_q <= restart ? '0 : byte_count_q + 1'b1;
			if (byte_count_q == '0) begin
				first_byte_q <= data_byte;
			end
			if (byte_count_q == CNT_W'(HEADER_BYTES - 1)) begin
				plen_q <= data_byte;
			end
		end
	end

endmodule

// ----- rtl/core/crc8fc_back.sv -----
// crc engine: runs the crc over tagged bytes and forms the status of each
module crc8fc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  crc8fc_pkg::job_t  job,
	input  logic [7:0]        crc_seed,
	output crc8fc_pkg::res_t  res
);
	import crc8fc_pkg::*;

	logic [7:0] crc_q;
	logic [7:0] crc_base;
	logic [7:0] crc_next;

	// crc update for the current word
	assign crc_base = (job.kind == KIND_FIRST) ? crc_seed : crc_q;
	assign crc_next = crc8_update(crc_base, job.data);

	// verdict decode
	always_comb begin
		res.plen = 8'd0;
		unique case (job.kind)
			KIND_FIRST, KIND_BODY: begin
				res.status = STATUS_UNFINISHED;
			end
			KIND_BAD: begin
				res.status = STATUS_INVALID;
			end
			KIND_CHECK: begin
				if (job.data == crc_q) begin
					res.status = STATUS_VALID;
					res.plen   = job.plen;
				end else begin
					res.status = STATUS_INVALID;
				end
			end
		endcase
	end

	// running crc, restarted from the seed on the first byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (take && (job.kind == KIND_FIRST || job.kind == KIND_BODY)) begin
			crc_q <= crc_next;
		end
	end

endmodule
